[rtl/bbtc_pkg.sv]
// Package for the block buffer tag cache: field widths, request and result codes,
// and the control word that the sequencer sends to the tag store.
// No dependencies.
package bbtc_pkg;

    localparam int ACTION_W = 2;
    localparam int BLOCK_W  = 15;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;

    // request codes
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SYNC  = 2'd2;

    // result codes
    localparam logic [KIND_W-1:0] KIND_DONE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH     = 2'd2;

    typedef struct packed {
        logic rd_en;    // read tag and valid bit at the read address
        logic wr_en;    // write tag and set valid at the write address
        logic clr_all;  // drop every valid bit (write, if any, still sets its own)
    } store_ctl_t;

endpackage

[rtl/bbtc_tag_store.sv]
// Tag store of the block buffer tag cache: tag memory with a registered read port
// and one valid flip-flop per slot. Depends on bbtc_pkg.
module bbtc_tag_store #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbtc_pkg::store_ctl_t              ctl,
    input  logic [$clog2(SLOTS)-1:0]          rd_addr,
    input  logic [$clog2(SLOTS)-1:0]          wr_addr,
    input  logic [bbtc_pkg::BLOCK_W-1:0]      wr_tag,
    output logic [bbtc_pkg::BLOCK_W-1:0]      rd_tag,
    output logic                              rd_valid
);
    import bbtc_pkg::*;

    logic [BLOCK_W-1:0] tag_mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic [SLOTS-1:0]   valid_next;
    logic [BLOCK_W-1:0] rd_tag_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (ctl.rd_en)
        begin
            rd_tag_reg <= tag_mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr_all)
        begin
            valid_next = '0;
        end
        if (ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_tag   = rd_tag_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[rtl/bbtc_seq.sv]
// Sequencer of the block buffer tag cache: sweeps the tag store one slot a cycle
// through a shared tag compare and issues the result words. Depends on bbtc_pkg.
module bbtc_seq #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bbtc_pkg::ACTION_W-1:0]     action,
    input  logic [bbtc_pkg::BLOCK_W-1:0]      block_number,
    output logic                              busy,
    output bbtc_pkg::store_ctl_t              ctl,
    output logic [$clog2(SLOTS)-1:0]          rd_addr,
    output logic [$clog2(SLOTS)-1:0]          wr_addr,
    output logic [bbtc_pkg::BLOCK_W-1:0]      wr_tag,
    input  logic [bbtc_pkg::BLOCK_W-1:0]      rd_tag,
    input  logic                              rd_valid,
    output logic                              res_valid,
    output logic [bbtc_pkg::KIND_W-1:0]       res_kind,
    output logic [$clog2(SLOTS)-1:0]          res_slot,
    output logic [bbtc_pkg::BLOCK_W-1:0]      res_block,
    output logic                              res_last
);
    import bbtc_pkg::*;

    localparam int            SW       = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SWEEP = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [BLOCK_W-1:0]  blk_reg, blk_next;
    logic [SW-1:0]       issue_idx_reg, issue_idx_next;
    logic                issue_live_reg, issue_live_next;
    logic [SW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_live_reg, cmp_live_next;
    logic                free_found_reg, free_found_next;
    logic [SW-1:0]       free_idx_reg, free_idx_next;
    logic [SW-1:0]       chosen_reg, chosen_next;
    logic                evict_reg, evict_next;

    logic                hit;
    logic                is_rw;

    assign hit   = rd_valid && (rd_tag == blk_reg);
    assign is_rw = (act_reg == ACT_READ) || (act_reg == ACT_WRITE);

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        blk_next        = blk_reg;
        issue_idx_next  = issue_idx_reg;
        issue_live_next = issue_live_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_live_next   = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        chosen_next     = chosen_reg;
        evict_next      = evict_reg;

        ctl       = '0;
        rd_addr   = issue_idx_reg;
        wr_addr   = chosen_reg;
        wr_tag    = blk_reg;
        res_valid = 1'b0;
        res_kind  = KIND_DONE;
        res_slot  = chosen_reg;
        res_block = blk_reg;
        res_last  = 1'b0;

        // read issue runs one slot ahead of the compare
        if (issue_live_reg && (state_reg == ST_SCAN || state_reg == ST_SWEEP))
        begin
            ctl.rd_en     = 1'b1;
            cmp_live_next = 1'b1;
            cmp_idx_next  = issue_idx_reg;
            if (issue_idx_reg == LAST_IDX)
            begin
                issue_live_next = 1'b0;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next        = action;
                    blk_next        = block_number;
                    issue_idx_next  = '0;
                    free_found_next = 1'b0;
                    evict_next      = 1'b0;
                    chosen_next     = '0;
                    if (action == ACT_READ || action == ACT_WRITE)
                    begin
                        issue_live_next = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else if (action == ACT_SYNC)
                    begin
                        issue_live_next = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        issue_live_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cmp_live_reg)
                begin
                    if (hit)
                    begin
                        chosen_next     = cmp_idx_reg;
                        issue_live_next = 1'b0;
                        cmp_live_next   = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        if (!rd_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            if (free_found_reg || !rd_valid)
                            begin
                                chosen_next = free_found_reg ? free_idx_reg : cmp_idx_reg;
                                ctl.wr_en   = 1'b1;
                                wr_addr     = chosen_next;
                                state_next  = (act_reg == ACT_READ) ? ST_FETCH : ST_DONE;
                            end
                            else
                            begin
                                // table full: write back every slot, then reuse slot 0
                                evict_next      = 1'b1;
                                issue_idx_next  = '0;
                                issue_live_next = 1'b1;
                                cmp_live_next   = 1'b0;
                                state_next      = ST_SWEEP;
                            end
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                if (cmp_live_reg)
                begin
                    if (rd_valid)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_WRITEBACK;
                        res_slot  = cmp_idx_reg;
                        res_block = rd_tag;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        chosen_next = '0;
                        if (evict_reg)
                        begin
                            ctl.clr_all = 1'b1;
                            ctl.wr_en   = 1'b1;
                            wr_addr     = '0;
                            state_next  = (act_reg == ACT_READ) ? ST_FETCH : ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_FETCH:
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_FETCH;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_DONE;
                res_block  = is_rw ? blk_reg : '0;
                res_last   = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_live_reg <= 1'b0;
            cmp_live_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            evict_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_live_reg <= issue_live_next;
            cmp_live_reg   <= cmp_live_next;
            free_found_reg <= free_found_next;
            evict_reg      <= evict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        blk_reg       <= blk_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_idx_reg  <= free_idx_next;
        chosen_reg    <= chosen_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[rtl/block_buffer_tag_cache.sv]
// Top level of the block buffer tag cache: sequencer, tag store and result register.
// Depends on bbtc_pkg, bbtc_seq and bbtc_tag_store.
//
// Usage
//   A request word (action, block_number) is taken at a rising edge with start high
//   and busy low. busy then stays high until the final result word is shown.
//   Result words (kind, slot, disk_block, last) each appear for exactly one cycle,
//   marked by strobe; the receiver takes every one and cannot stall the block.
//   Every request ends with a done word that has last set.
// Operation
//   Read or write lookup: the tag store is swept one slot a cycle through a single
//   tag compare; a hit stops the sweep. A miss into a free slot adds a fetch word
//   (read) and the done word. A miss on a full table sweeps again, one write-back
//   word a cycle, then fetch (read) and done. Sync sweeps once, one write-back per
//   valid slot, then done. The rate is set by the single read port of the tag
//   memory and the one compare.
// Reset
//   rst_n clears every valid bit at once: all slots free, the block idle.
//   No clearing pass is needed; tags of free slots are never reported.
module block_buffer_tag_cache #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bbtc_pkg::ACTION_W-1:0]     action,
    input  logic [bbtc_pkg::BLOCK_W-1:0]      block_number,
    output logic                              strobe,
    output logic [bbtc_pkg::KIND_W-1:0]       kind,
    output logic [bbtc_pkg::SLOT_W-1:0]       slot,
    output logic [bbtc_pkg::BLOCK_W-1:0]      disk_block,
    output logic                              last
);
    import bbtc_pkg::*;

    localparam int SW = $clog2(SLOTS);

    store_ctl_t         ctl;
    logic [SW-1:0]      rd_addr;
    logic [SW-1:0]      wr_addr;
    logic [BLOCK_W-1:0] wr_tag;
    logic [BLOCK_W-1:0] rd_tag;
    logic               rd_valid;

    logic               res_valid;
    logic [KIND_W-1:0]  res_kind;
    logic [SW-1:0]      res_slot;
    logic [BLOCK_W-1:0] res_block;
    logic               res_last;

    // result register: each word is held for exactly one cycle
    logic               strobe_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic               last_reg;

    bbtc_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .block_number (block_number),
        .busy         (busy),
        .ctl          (ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_tag       (wr_tag),
        .rd_tag       (rd_tag),
        .rd_valid     (rd_valid),
        .res_valid    (res_valid),
        .res_kind     (res_kind),
        .res_slot     (res_slot),
        .res_block    (res_block),
        .res_last     (res_last)
    );

    bbtc_tag_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_tag   (wr_tag),
        .rd_tag   (rd_tag),
        .rd_valid (rd_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res_valid;
        end
    end

    // payload: load only with a word, truncate or extend the slot to the port width
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            kind_reg  <= res_kind;
            slot_reg  <= SLOT_W'(res_slot);
            block_reg <= res_block;
            last_reg  <= res_last;
        end
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign slot       = slot_reg;
    assign disk_block = block_reg;
    assign last       = last_reg;

endmodule

[rtl/bbtc_checker.sv]
// Port-level checker for the block buffer tag cache, bound to the top level.
// Depends on bbtc_pkg.
module bbtc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          strobe,
    input logic [bbtc_pkg::KIND_W-1:0]   kind,
    input logic                          last
);
    import bbtc_pkg::*;

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted request");

    // the final word frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("busy still high with final word");

    // intermediate words only appear while a request is in work
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("intermediate word while idle");

    // done and last go together
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((kind == KIND_DONE) == last))
        else $error("done word and last disagree");

    // a fetch is followed directly by the done word
    a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_FETCH |=> strobe && kind == KIND_DONE && last)
        else $error("fetch not followed by done");

endmodule

bind block_buffer_tag_cache bbtc_checker u_bbtc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .kind   (kind),
    .last   (last)
);

[verif/block_buffer_tag_cache_tb.sv]
// Testbench for block_buffer_tag_cache: drives read, write, sync and unused requests
// and checks every result word against a tag-table predictor kept in this file.
// Depends on bbtc_pkg and block_buffer_tag_cache.
module block_buffer_tag_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbtc_pkg::*;

    localparam int SLOTS = 16;
    // Action code 3 is not decoded by the block; it must answer with a bare done word.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    // Cycles with nothing accepted on either side before the run is declared hung.
    // The longest quiet stretch of a correct run is a full sweep plus a sender gap.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to keep watching after the last expected word, for stray words.
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [BLOCK_W-1:0] disk_block;
        logic               last;
    } result_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ACTION_W-1:0] action = '0;
    logic [BLOCK_W-1:0]  block_number = '0;
    logic                strobe;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [BLOCK_W-1:0]  disk_block;
    logic                last;

    // Predictor copy of the tag table.
    logic [SLOTS-1:0]    slot_used;
    logic [BLOCK_W-1:0]  slot_block [SLOTS];

    // Result words still owed by the block, oldest first.
    result_word_t        pending_words [$];
    result_word_t        want;
    int                  errors = 0;
    int                  quiet_cycles = 0;
    // When low, the sender never pauses between requests.
    logic                gaps_on = 1'b1;
    // Hot set of block numbers, so that random traffic hits and fills the table.
    logic [BLOCK_W-1:0]  hot_blocks [20];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    block_buffer_tag_cache #(
        .SLOTS(SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .block_number (block_number),
        .strobe       (strobe),
        .kind         (kind),
        .slot         (slot),
        .disk_block   (disk_block),
        .last         (last)
    );

    function automatic result_word_t make_word(logic [KIND_W-1:0] k, int s,
                                               logic [BLOCK_W-1:0] blk, logic l);
        result_word_t w;
        w.kind       = k;
        w.slot       = SLOT_W'(s);
        w.disk_block = blk;
        w.last       = l;
        return w;
    endfunction

    // Work out every result word one request causes and update the tag table.
    function automatic void predict_request(logic [ACTION_W-1:0] act,
                                            logic [BLOCK_W-1:0] blk);
        int i;
        int hit;
        int free;
        hit  = -1;
        free = -1;
        if (act == ACT_SYNC)
        begin
            // Write back every valid slot in slot order; the table is kept.
            for (i = 0; i < SLOTS; i++)
                if (slot_used[i])
                    pending_words.push_back(make_word(KIND_WRITEBACK, i, slot_block[i], 1'b0));
            pending_words.push_back(make_word(KIND_DONE, 0, '0, 1'b1));
            return;
        end
        if (act == ACT_UNUSED)
        begin
            pending_words.push_back(make_word(KIND_DONE, 0, '0, 1'b1));
            return;
        end
        for (i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_used[i] && slot_block[i] == blk)
                hit = i;
        if (hit >= 0)
        begin
            pending_words.push_back(make_word(KIND_DONE, hit, blk, 1'b1));
            return;
        end
        for (i = 0; i < SLOTS; i++)
            if (free < 0 && !slot_used[i])
                free = i;
        if (free < 0)
        begin
            // Full table: flush every slot, empty the table, reuse slot 0.
            for (i = 0; i < SLOTS; i++)
                pending_words.push_back(make_word(KIND_WRITEBACK, i, slot_block[i], 1'b0));
            slot_used = '0;
            free = 0;
        end
        slot_used[free]  = 1'b1;
        slot_block[free] = blk;
        if (act == ACT_READ)
            pending_words.push_back(make_word(KIND_FETCH, free, blk, 1'b0));
        pending_words.push_back(make_word(KIND_DONE, free, blk, 1'b1));
    endfunction

    // Offer one request word and hold it until the block takes it. Leave start high
    // afterwards so back-to-back requests need no dead cycle.
    task automatic send_request(logic [ACTION_W-1:0] act, logic [BLOCK_W-1:0] blk);
        if (gaps_on && $urandom_range(99) < 13)
        begin
            // Pause with garbage on the request fields; start low makes it harmless.
            start        <= 1'b0;
            action       <= ACTION_W'($urandom);
            block_number <= BLOCK_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        block_number <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(act, blk);
    endtask

    // Extremes of the block field, a read on miss and hit, a write on miss, the unused
    // action code and a sync over a partly filled table.
    task automatic test_basic_ops();
        send_request(ACT_READ, '0);
        send_request(ACT_READ, '0);
        send_request(ACT_WRITE, '1);
        send_request(ACT_READ, '1);
        send_request(ACT_UNUSED, '1);
        send_request(ACT_SYNC, '1);
    endtask

    // Fill the table, then miss on it: sixteen write-backs, slot 0 reused. Then check
    // that the flushed table hands out slot 1 next and that sync sees the new contents.
    task automatic test_full_table_eviction();
        int i;
        for (i = 0; i < SLOTS - 2; i++)
            send_request((i % 2) ? ACT_WRITE : ACT_READ, BLOCK_W'(15'h0100 + i));
        send_request(ACT_READ, 15'h2a5a);
        send_request(ACT_WRITE, 15'h55a5);
        send_request(ACT_SYNC, '0);
        send_request(ACT_READ, '0);
    endtask

    // Mostly well-formed traffic over a small set of hot blocks, so the table fills,
    // hits and overflows often; the rest is wide random blocks, syncs and unused codes.
    task automatic test_random_traffic(int count, logic with_gaps);
        int n;
        int pick;
        logic [ACTION_W-1:0] act;
        logic [BLOCK_W-1:0]  blk;
        gaps_on = with_gaps;
        for (n = 0; n < 20; n++)
            hot_blocks[n] = BLOCK_W'($urandom);
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                act = ACT_READ;
            else if (pick < 88)
                act = ACT_WRITE;
            else if (pick < 95)
                act = ACT_SYNC;
            else
                act = ACT_UNUSED;
            if ($urandom_range(99) < 75)
                blk = hot_blocks[$urandom_range(19)];
            else
                blk = BLOCK_W'($urandom);
            // Drift the hot set slowly so old tags age out.
            if ($urandom_range(99) < 5)
                hot_blocks[$urandom_range(19)] = BLOCK_W'($urandom);
            send_request(act, blk);
        end
        gaps_on = 1'b1;
    endtask

    // Check every result word against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word kind %0d slot %0d disk_block %0d last %0d",
                         $time, kind, slot, disk_block, last);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
                    errors++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t: slot expected %0d got %0d", $time, want.slot, slot);
                    errors++;
                end
                if (disk_block !== want.disk_block)
                begin
                    $display("%0t: disk_block expected %0d got %0d",
                             $time, want.disk_block, disk_block);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0d got %0d", $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    // Count quiet cycles; any request or result word taken restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("block_buffer_tag_cache_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int i;
        slot_used = '0;
        for (i = 0; i < SLOTS; i++)
            slot_block[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_table_eviction();
        test_random_traffic(130, 1'b1);
        test_random_traffic(130, 1'b0);

        // Drop start, wait for every owed word, then watch a while for strays.
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
            errors++;
        end
        if (errors == 0)
            $display("block_buffer_tag_cache_tb OK");
        else
            $display("block_buffer_tag_cache_tb NOT OK");
        $finish;
    end

endmodule
